// ----- hw/rtl/wsfd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package wsfd_pkg;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_TRUNC   = 2'd1,
    ST_UNKNOWN = 2'd2
  } status_t;

  // Parser phase, one-hot
  typedef enum logic [4:0] {
    PH_HDR0    = 5'b00001,
    PH_HDR1    = 5'b00010,
    PH_EXTLEN  = 5'b00100,
    PH_MASKKEY = 5'b01000,
    PH_PAYLOAD = 5'b10000
  } phase_t;

  // Header field constants
  localparam logic [7:0] FIN_BIT     = 8'h80;
  localparam logic [7:0] OPCODE_MASK = 8'h0F;
  localparam logic [7:0] LEN_MASK    = 8'h7F;
  localparam logic [6:0] LEN_CODE_16 = 7'd126;
  localparam logic [6:0] LEN_CODE_64 = 7'd127;

  // Known opcodes
  localparam logic [3:0] OP_TEXT   = 4'h1;
  localparam logic [3:0] OP_BINARY = 4'h2;
  localparam logic [3:0] OP_CLOSE  = 4'h8;
  localparam logic [3:0] OP_PING   = 4'h9;
  localparam logic [3:0] OP_PONG   = 4'hA;

  // Field byte counts
  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;
  localparam logic [3:0] KEY_BYTES   = 4'd4;

  // One decoded result
  typedef struct packed {
    status_t     status;
    logic        is_payload;
    logic [7:0]  out_byte;
    logic        frame_end;
    logic        fin_flag;
    logic [3:0]  frame_opcode;
    logic        is_masked;
    logic [63:0] frame_length;
  } result_t;

  function automatic logic opcode_known(input logic [3:0] op);
    return (op == OP_TEXT) || (op == OP_BINARY) || (op == OP_CLOSE) ||
           (op == OP_PING) || (op == OP_PONG);
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/wsfd_in_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface wsfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       stream_end;

  modport source (output valid, output in_byte, output stream_end, input ready);
  modport sink   (input valid, input in_byte, input stream_end, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/wsfd_out_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface wsfd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        is_payload;
  logic [7:0]  out_byte;
  logic        frame_end;
  logic        fin_flag;
  logic [3:0]  frame_opcode;
  logic        is_masked;
  logic [63:0] frame_length;

  modport source (output valid, output status, output is_payload, output out_byte,
                  output frame_end, output fin_flag, output frame_opcode,
                  output is_masked, output frame_length, input ready);
  modport sink   (input valid, input status, input is_payload, input out_byte,
                  input frame_end, input fin_flag, input frame_opcode,
                  input is_masked, input frame_length, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/websocket_frame_decoder.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Payload                                 Transfer
// ingress   in         in_byte, stream_end                     valid & ready
// egress    out        status, is_payload, out_byte,           valid & ready
//                      frame_end, fin_flag, frame_opcode,
//                      is_masked, frame_length
//
// One byte per cycle while ingress.ready is high; each byte gives one registered result.
// The parser state updates in the cycle of the transfer; a result register and
// a skid register behind it hold up to two results.
// ingress.ready drops only while the skid register is full.
// rst is synchronous, active high: parser returns to the first header byte and
// both result registers empty.

module websocket_frame_decoder (
  input  wire logic   clk,
  input  wire logic   rst,
  wsfd_in_if.sink     ingress,
  wsfd_out_if.source  egress
);
  import wsfd_pkg::*;

  // Parser state
  phase_t      phase, phase_next;
  logic        fin_reg, fin_next;
  logic [3:0]  opcode_reg, opcode_next;
  logic        mask_flag_reg, mask_flag_next;
  logic [63:0] length_accum, length_next;
  logic [3:0]  bytes_left, bytes_left_next;
  logic [31:0] mask_key_reg, mask_key_next;
  logic [63:0] payload_remaining, remaining_next;
  logic [1:0]  mask_index, mask_index_next;

  // Result buffering
  result_t     out_reg, skid_reg, res_c;
  logic        out_valid, skid_valid;

  logic        accept, take;
  logic        ended_c, len_done_c, begin_c, trunc_c;
  logic [7:0]  b;
  logic [6:0]  code;
  logic [7:0]  key_byte;
  logic [7:0]  ob_c;

  assign b      = ingress.in_byte;
  assign code   = 7'(b & LEN_MASK);
  assign accept = ingress.valid && ingress.ready;
  assign take   = out_valid && egress.ready;

  assign ingress.ready = !skid_valid;

  // Key byte for the current payload position, first received byte first
  always_comb begin
    unique case (mask_index)
      2'd0:    key_byte = mask_key_reg[31:24];
      2'd1:    key_byte = mask_key_reg[23:16];
      2'd2:    key_byte = mask_key_reg[15:8];
      default: key_byte = mask_key_reg[7:0];
    endcase
  end

  // Next-state and result for one byte
  always_comb begin
    phase_next      = phase;
    fin_next        = fin_reg;
    opcode_next     = opcode_reg;
    mask_flag_next  = mask_flag_reg;
    length_next     = length_accum;
    bytes_left_next = bytes_left;
    mask_key_next   = mask_key_reg;
    remaining_next  = payload_remaining;
    mask_index_next = mask_index;
    ended_c         = 1'b0;
    len_done_c      = 1'b0;
    begin_c         = 1'b0;
    ob_c            = 8'd0;
    res_c           = '0;

    unique case (phase)
      PH_HDR0: begin
        fin_next        = (b & FIN_BIT) != 8'd0;
        opcode_next     = 4'(b & OPCODE_MASK);
        mask_flag_next  = 1'b0;
        length_next     = '0;
        mask_key_next   = '0;
        mask_index_next = '0;
        remaining_next  = '0;
        bytes_left_next = '0;
        phase_next      = PH_HDR1;
      end
      PH_HDR1: begin
        mask_flag_next = (b & FIN_BIT) != 8'd0;
        if (code < LEN_CODE_16) begin
          length_next = {57'd0, code};
          len_done_c  = 1'b1;
        end else begin
          length_next     = '0;
          bytes_left_next = (code == LEN_CODE_64) ? EXT64_BYTES : EXT16_BYTES;
          phase_next      = PH_EXTLEN;
        end
      end
      PH_EXTLEN: begin
        length_next     = {length_accum[55:0], b};
        bytes_left_next = bytes_left - 4'd1;
        len_done_c      = (bytes_left_next == 4'd0);
      end
      PH_MASKKEY: begin
        mask_key_next   = {mask_key_reg[23:0], b};
        bytes_left_next = bytes_left - 4'd1;
        begin_c         = (bytes_left_next == 4'd0);
      end
      PH_PAYLOAD: begin
        ob_c            = mask_flag_reg ? (b ^ key_byte) : b;
        mask_index_next = mask_index + 2'd1;
        remaining_next  = payload_remaining - 64'd1;
        if (remaining_next == 64'd0) begin
          ended_c    = 1'b1;
          phase_next = PH_HDR0;
        end
      end
      default: phase_next = PH_HDR0;
    endcase

    // Length complete: mask key next, or straight to payload
    if (len_done_c) begin
      if (mask_flag_next) begin
        bytes_left_next = KEY_BYTES;
        phase_next      = PH_MASKKEY;
      end else begin
        begin_c = 1'b1;
      end
    end

    // Payload start; an empty payload ends the frame here
    if (begin_c) begin
      remaining_next  = length_next;
      mask_index_next = '0;
      if (length_next == 64'd0) begin
        ended_c    = 1'b1;
        phase_next = PH_HDR0;
      end else begin
        phase_next = PH_PAYLOAD;
      end
    end

    trunc_c = ingress.stream_end && !ended_c;

    if (ended_c) begin
      res_c.status = opcode_known(opcode_reg) ? ST_OK : ST_UNKNOWN;
    end else if (ingress.stream_end) begin
      res_c.status = ST_TRUNC;
    end else begin
      res_c.status = ST_OK;
    end
    res_c.is_payload   = (phase == PH_PAYLOAD);
    res_c.out_byte     = ob_c;
    res_c.frame_end    = ended_c;
    res_c.fin_flag     = fin_next;
    res_c.frame_opcode = opcode_next;
    res_c.is_masked    = mask_flag_next;
    res_c.frame_length = length_next;
  end

  // Parser state registers; truncation returns to reset state
  always_ff @(posedge clk) begin
    if (rst || (accept && trunc_c)) begin
      phase             <= PH_HDR0;
      fin_reg           <= 1'b0;
      opcode_reg        <= '0;
      mask_flag_reg     <= 1'b0;
      length_accum      <= '0;
      bytes_left        <= '0;
      mask_key_reg      <= '0;
      payload_remaining <= '0;
      mask_index        <= '0;
    end else if (accept) begin
      phase             <= phase_next;
      fin_reg           <= fin_next;
      opcode_reg        <= opcode_next;
      mask_flag_reg     <= mask_flag_next;
      length_accum      <= length_next;
      bytes_left        <= bytes_left_next;
      mask_key_reg      <= mask_key_next;
      payload_remaining <= remaining_next;
      mask_index        <= mask_index_next;
    end
  end

  // Result register with skid stage behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (accept) begin
      if (out_valid && !take) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (take) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (out_valid && !take) begin
        skid_reg <= res_c;
      end else begin
        out_reg <= res_c;
      end
    end else if (take && skid_valid) begin
      out_reg <= skid_reg;
    end
  end

  assign egress.valid        = out_valid;
  assign egress.status       = out_reg.status;
  assign egress.is_payload   = out_reg.is_payload;
  assign egress.out_byte     = out_reg.out_byte;
  assign egress.frame_end    = out_reg.frame_end;
  assign egress.fin_flag     = out_reg.fin_flag;
  assign egress.frame_opcode = out_reg.frame_opcode;
  assign egress.is_masked    = out_reg.is_masked;
  assign egress.frame_length = out_reg.frame_length;

`ifndef ASSERT_OFF
  // Skid stage only fills behind a waiting result
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid register full while result register empty");

  // A truncating byte leaves the parser at the first header byte
  a_trunc_resets: assert property (@(posedge clk) disable iff (rst)
    (accept && trunc_c) |=> (phase == PH_HDR0))
    else $error("parser not reset after truncation");

  // A completed frame never reports truncation
  a_end_not_trunc: assert property (@(posedge clk) disable iff (rst)
    (egress.valid && egress.frame_end) |-> (egress.status != ST_TRUNC))
    else $error("frame end reported with truncation status");

  // Header bytes carry a zero data byte
  a_hdr_zero_byte: assert property (@(posedge clk) disable iff (rst)
    (egress.valid && !egress.is_payload) |-> (egress.out_byte == 8'd0))
    else $error("non-zero data byte on a header result");
`endif

endmodule

`default_nettype wire

// ----- test/wsfd_frame_check.sv -----
`timescale 1ns / 1ps

// Watches both channels, decodes the accepted byte stream alongside the block and
// compares every accepted result with the oldest decoded expectation.
module wsfd_frame_check (
  input  logic clk,
  input  logic rst,
  wsfd_in_if   ingress,
  wsfd_out_if  egress,
  output int   fail_count,
  output int   backlog
);
  import wsfd_pkg::*;

  // Parser state mirrored from the block
  phase_t      ph;
  logic        fin;
  logic [3:0]  opc;
  logic        masked;
  logic [63:0] len_acc;
  logic [3:0]  field_left;
  logic [31:0] key;
  logic [63:0] remaining;
  logic [1:0]  key_idx;

  result_t     expected_q[$];
  int          mismatches = 0;
  int          waiting = 0;

  assign fail_count = mismatches;
  assign backlog    = waiting;

  task automatic report(input string what, input logic [63:0] got,
                        input logic [63:0] want);
    $display("%0t: %s: got %0h, expected %0h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic clear_parser();
    ph         = PH_HDR0;
    fin        = 1'b0;
    opc        = '0;
    masked     = 1'b0;
    len_acc    = '0;
    field_left = '0;
    key        = '0;
    remaining  = '0;
    key_idx    = '0;
  endtask

  // Length (and key) complete: payload follows, or the frame ends here when empty
  task automatic start_payload(output logic done);
    remaining = len_acc;
    key_idx   = '0;
    done      = 1'b0;
    if (remaining == 0) begin
      done = 1'b1;
      ph   = PH_HDR0;
    end else begin
      ph = PH_PAYLOAD;
    end
  endtask

  task automatic length_complete(output logic done);
    done = 1'b0;
    if (masked) begin
      field_left = KEY_BYTES;
      ph         = PH_MASKKEY;
    end else begin
      start_payload(done);
    end
  endtask

  // One stream byte through the parser, giving the result it should cause
  task automatic decode_byte(input logic [7:0] b, input logic last_byte,
                             output result_t r);
    logic       done;
    logic [7:0] k;
    done = 1'b0;
    k    = '0;
    r    = '0;
    case (ph)
      PH_HDR0: begin
        fin        = b[7];
        opc        = b[3:0];
        masked     = 1'b0;
        len_acc    = '0;
        key        = '0;
        key_idx    = '0;
        remaining  = '0;
        field_left = '0;
        ph         = PH_HDR1;
      end
      PH_HDR1: begin
        masked = b[7];
        if (b[6:0] < LEN_CODE_16) begin
          len_acc = {57'd0, b[6:0]};
          length_complete(done);
        end else begin
          len_acc    = '0;
          field_left = (b[6:0] == LEN_CODE_16) ? EXT16_BYTES : EXT64_BYTES;
          ph         = PH_EXTLEN;
        end
      end
      PH_EXTLEN: begin
        len_acc    = {len_acc[55:0], b};
        field_left = field_left - 4'd1;
        if (field_left == 0) length_complete(done);
      end
      PH_MASKKEY: begin
        key        = {key[23:0], b};
        field_left = field_left - 4'd1;
        if (field_left == 0) start_payload(done);
      end
      PH_PAYLOAD: begin
        if (masked) k = key[8 * (3 - key_idx) +: 8];
        r.out_byte   = b ^ k;
        r.is_payload = 1'b1;
        key_idx      = key_idx + 2'd1;
        remaining    = remaining - 64'd1;
        if (remaining == 0) begin
          done = 1'b1;
          ph   = PH_HDR0;
        end
      end
      default: ph = PH_HDR0;
    endcase

    // Status: opcode check at frame end, truncation at a stream end elsewhere
    if (done) begin
      case (opc)
        OP_TEXT, OP_BINARY, OP_CLOSE, OP_PING, OP_PONG: r.status = ST_OK;
        default: r.status = ST_UNKNOWN;
      endcase
    end else if (last_byte) begin
      r.status = ST_TRUNC;
    end else begin
      r.status = ST_OK;
    end
    r.frame_end    = done;
    r.fin_flag     = fin;
    r.frame_opcode = opc;
    r.is_masked    = masked;
    r.frame_length = len_acc;

    if (last_byte && !done) clear_parser();
  endtask

  // Results are compared before the byte of the same edge is decoded: a result
  // never belongs to the transfer at its own edge.
  always @(posedge clk) begin : watch
    result_t want;
    result_t fresh;
    if (rst) begin
      clear_parser();
      expected_q.delete();
    end else begin
      if (egress.valid && egress.ready) begin
        if (expected_q.size() == 0) begin
          report("result with nothing expected", egress.out_byte, 64'd0);
        end else begin
          want = expected_q.pop_front();
          if (egress.status !== want.status)
            report("status", egress.status, want.status);
          if (egress.is_payload !== want.is_payload)
            report("is_payload", egress.is_payload, want.is_payload);
          if (egress.out_byte !== want.out_byte)
            report("out_byte", egress.out_byte, want.out_byte);
          if (egress.frame_end !== want.frame_end)
            report("frame_end", egress.frame_end, want.frame_end);
          if (egress.fin_flag !== want.fin_flag)
            report("fin_flag", egress.fin_flag, want.fin_flag);
          if (egress.frame_opcode !== want.frame_opcode)
            report("frame_opcode", egress.frame_opcode, want.frame_opcode);
          if (egress.is_masked !== want.is_masked)
            report("is_masked", egress.is_masked, want.is_masked);
          if (egress.frame_length !== want.frame_length)
            report("frame_length", egress.frame_length, want.frame_length);
        end
      end
      if (ingress.valid && ingress.ready) begin
        decode_byte(ingress.in_byte, ingress.stream_end, fresh);
        expected_q = {expected_q, fresh};
      end
    end
    waiting = expected_q.size();
  end

endmodule

// ----- test/tb_websocket_frame_decoder.sv -----
`timescale 1ns / 1ps

module tb_websocket_frame_decoder;
  import wsfd_pkg::*;

  logic clk;
  logic rst;
  int   fails;
  int   backlog;
  int   idle_pct = 0;
  int   stall_pct = 0;
  int   items_sent = 0;

  wsfd_in_if  ingress_ch ();
  wsfd_out_if egress_ch ();

  websocket_frame_decoder uut (
    .clk     (clk),
    .rst     (rst),
    .ingress (ingress_ch),
    .egress  (egress_ch)
  );

  wsfd_frame_check frame_check (
    .clk        (clk),
    .rst        (rst),
    .ingress    (ingress_ch),
    .egress     (egress_ch),
    .fail_count (fails),
    .backlog    (backlog)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Receiver stalls at random
  always @(negedge clk) begin
    egress_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // One byte transfer, with random idle cycles ahead of it
  task automatic send_byte(input logic [7:0] b, input logic last_byte);
    while ($urandom_range(0, 99) < idle_pct) begin
      ingress_ch.valid <= 1'b0;
      @(negedge clk);
    end
    ingress_ch.valid      <= 1'b1;
    ingress_ch.in_byte    <= b;
    ingress_ch.stream_end <= last_byte;
    @(posedge clk);
    while (!ingress_ch.ready) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  // Well-formed frame with random content; some end the stream, some are cut short
  task automatic random_frame();
    logic [7:0]  fb[$];
    logic [63:0] len;
    logic [6:0]  code;
    logic        masked;
    logic        mark_end;
    int          pick;
    int          body;
    int          last_idx;
    masked = 1'($urandom_range(0, 1));
    pick   = $urandom_range(0, 99);
    if (pick < 55) begin
      len  = 64'($urandom_range(0, 12));
      code = len[6:0];
    end else if (pick < 62) begin
      len  = 64'($urandom_range(13, 125));
      code = len[6:0];
    end else if (pick < 77) begin
      code = LEN_CODE_16;
      len  = ($urandom_range(0, 9) == 0) ? 64'($urandom_range(126, 300))
                                         : 64'($urandom_range(0, 40));
    end else if (pick < 90) begin
      code = LEN_CODE_64;
      len  = 64'($urandom_range(0, 30));
    end else begin
      // huge lengths: when longer than the body sent, the stream ends inside them
      code = $urandom_range(0, 1) ? LEN_CODE_16 : LEN_CODE_64;
      len  = {$urandom, $urandom};
      if (code == LEN_CODE_16) len = {48'd0, len[15:0]};
    end

    fb = {fb, 8'($urandom)};
    fb = {fb, {masked, code}};
    if (code == LEN_CODE_16) begin
      fb = {fb, len[15:8]};
      fb = {fb, len[7:0]};
    end else if (code == LEN_CODE_64) begin
      for (int i = 7; i >= 0; i--) fb = {fb, len[8 * i +: 8]};
    end
    if (masked) repeat (4) fb = {fb, 8'($urandom)};
    body = (len > 64'd48) ? int'($urandom_range(0, 8)) : int'(len);
    repeat (body) fb = {fb, 8'($urandom)};

    last_idx = fb.size() - 1;
    pick     = $urandom_range(0, 99);
    if (64'(body) < len) begin
      mark_end = 1'b1;
    end else if (pick < 8) begin
      last_idx = $urandom_range(0, fb.size() - 1);
      mark_end = 1'b1;
    end else begin
      mark_end = (pick < 18);
    end
    for (int i = 0; i <= last_idx; i++) send_byte(fb[i], mark_end && (i == last_idx));
  endtask

  // Directed stream: {stream_end, byte}
  logic [8:0] directed[] = '{
    // unknown opcode, RSV bits set, empty payload ends on second byte
    {1'b0, 8'hFF}, {1'b0, 8'h00},
    // masked text, key wraps, stream end on the last payload byte
    {1'b0, 8'h81}, {1'b0, 8'h85},
    {1'b0, 8'hFF}, {1'b0, 8'h00}, {1'b0, 8'hA5}, {1'b0, 8'h5A},
    {1'b0, 8'h00}, {1'b0, 8'hFF}, {1'b0, 8'h12}, {1'b0, 8'h34}, {1'b1, 8'h56},
    // continuation, 16-bit length of zero, ends on last length byte
    {1'b0, 8'h00}, {1'b0, 8'h7E}, {1'b0, 8'h00}, {1'b0, 8'h00},
    // stream ends on a first header byte
    {1'b1, 8'h88},
    // masked pong with all-ones 64-bit length, cut at the last length byte
    {1'b0, 8'h0A}, {1'b0, 8'hFF},
    {1'b0, 8'hFF}, {1'b0, 8'hFF}, {1'b0, 8'hFF}, {1'b0, 8'hFF},
    {1'b0, 8'hFF}, {1'b0, 8'hFF}, {1'b0, 8'hFF}, {1'b1, 8'hFF},
    // binary cut inside its payload
    {1'b0, 8'h02}, {1'b0, 8'h03}, {1'b0, 8'hAA}, {1'b1, 8'hBB}
  };

  int idle_set[4]  = '{0, 59, 0, 7};
  int stall_set[4] = '{0, 0, 59, 7};

  initial begin
    rst                   = 1'b1;
    ingress_ch.valid      = 1'b0;
    ingress_ch.in_byte    = '0;
    ingress_ch.stream_end = 1'b0;
    egress_ch.ready       = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed[i]) send_byte(directed[i][7:0], directed[i][8]);

    // Random frames over the idle and stall phases
    for (int p = 0; p < 4; p++) begin
      idle_pct  = idle_set[p];
      stall_pct = stall_set[p];
      while (items_sent < directed.size() + (p + 1) * 255) random_frame();
    end
    ingress_ch.valid <= 1'b0;
    stall_pct = 0;

    while (backlog != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    if (fails == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
